FILE: rtl/lkps_pkg.sv
// Package for the lane keeping PD steering block: field widths, register
// reset values, mode and register index codes, and the sequencer program.
// No dependencies.
`default_nettype none
package lkps_pkg;

	localparam int SPEED_W   = 12;
	localparam int QUAL_W    = 8;
	localparam int OFFSET_W  = 14;
	localparam int TORQUE_W  = 12;
	localparam int MODE_W    = 2;
	localparam int INTENS_W  = 2;
	localparam int GAIN_W    = 16;
	localparam int RATE_W    = 10;
	localparam int LIMIT_W   = 12;
	localparam int WARN_W    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int PC_W      = 2;

	localparam logic [SPEED_W-1:0] MIN_SPEED_RST     = 12'd600;
	localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd896;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 16'd307;
	localparam logic [RATE_W-1:0]  RATE_SCALE_RST    = 10'd50;
	localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST  = 12'd1280;
	localparam logic [WARN_W-1:0]  WARN_OFFSET_RST   = 13'd276;
	localparam logic [LIMIT_W-1:0] ACTIVE_TORQUE_RST = 12'd128;

	localparam logic [INTENS_W-1:0] INTENS_ON  = 2'd3;
	localparam logic [INTENS_W-1:0] INTENS_OFF = 2'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF       = 2'd0,
		MODE_READY     = 2'd1,
		MODE_PREP      = 2'd2,
		MODE_INTERVENE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SPEED     = 3'd0,
		CFG_GAIN_P        = 3'd1,
		CFG_GAIN_D        = 3'd2,
		CFG_RATE_SCALE    = 3'd3,
		CFG_TORQUE_LIMIT  = 3'd4,
		CFG_WARN_OFFSET   = 3'd5,
		CFG_ACTIVE_TORQUE = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MSEL_NONE = 2'd0,
		MSEL_RATE = 2'd1,
		MSEL_D    = 2'd2,
		MSEL_P    = 2'd3
	} msel_t;

	typedef enum logic [1:0] {
		COND_NEVER   = 2'd0,
		COND_NOREQ   = 2'd1,
		COND_NOPD    = 2'd2,
		COND_OUTBUSY = 2'd3
	} cond_t;

	typedef struct packed {
		logic            take;
		msel_t           msel;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            commit;
	} ctrl_t;

	// Step program: accept and form the rate, gain_d product, gain_p product
	// added, then commit the new status. A taken jump goes to target.
	function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{take: 1'b0, msel: MSEL_NONE, cond: COND_NEVER, target: 2'd0, commit: 1'b0};
		case (pc)
			2'd0: w = '{take: 1'b1, msel: MSEL_RATE, cond: COND_NOREQ, target: 2'd0,
				commit: 1'b0};
			2'd1: w = '{take: 1'b0, msel: MSEL_D, cond: COND_NOPD, target: 2'd3,
				commit: 1'b0};
			2'd2: w = '{take: 1'b0, msel: MSEL_P, cond: COND_NEVER, target: 2'd0,
				commit: 1'b0};
			2'd3: w = '{take: 1'b0, msel: MSEL_NONE, cond: COND_OUTBUSY, target: 2'd3,
				commit: 1'b1};
			default: w = '{take: 1'b0, msel: MSEL_NONE, cond: COND_NEVER, target: 2'd0,
				commit: 1'b0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lkps_cfg_if.sv
// Configuration write channel of the lane keeping block.
// Depends on lkps_pkg for the index and data widths.
`default_nettype none
interface lkps_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lkps_pkg::CFG_IDX_W-1:0] index;
	logic [lkps_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lkps_in_if.sv
// Input channel of the lane keeping block: one control tick per request.
// Depends on lkps_pkg for the field widths.
`default_nettype none
interface lkps_in_if;
	logic                                valid;
	logic                                ready;
	logic [lkps_pkg::SPEED_W-1:0]         speed;
	logic [lkps_pkg::QUAL_W-1:0]          qual_left;
	logic [lkps_pkg::QUAL_W-1:0]          qual_right;
	logic signed [lkps_pkg::OFFSET_W-1:0] left_offset;
	logic signed [lkps_pkg::OFFSET_W-1:0] right_offset;
	logic                                blinker_left;
	logic                                blinker_right;
	logic                                toggle;

	modport source (output valid, output speed, output qual_left, output qual_right,
		output left_offset, output right_offset, output blinker_left, output blinker_right,
		output toggle, input ready);
	modport sink (input valid, input speed, input qual_left, input qual_right,
		input left_offset, input right_offset, input blinker_left, input blinker_right,
		input toggle, output ready);
endinterface
`default_nettype wire

FILE: rtl/lkps_out_if.sv
// Result channel of the lane keeping block: the status after each tick.
// Depends on lkps_pkg for the field widths.
`default_nettype none
interface lkps_out_if;
	logic                                valid;
	logic                                ready;
	logic [lkps_pkg::MODE_W-1:0]          mode;
	logic signed [lkps_pkg::TORQUE_W-1:0] torque;
	logic                                depart_left;
	logic                                depart_right;
	logic                                active;
	logic [lkps_pkg::INTENS_W-1:0]        intensity;

	modport source (output valid, output mode, output torque, output depart_left,
		output depart_right, output active, output intensity, input ready);
	modport sink (input valid, input mode, input torque, input depart_left,
		input depart_right, input active, input intensity, output ready);
endinterface
`default_nettype wire

FILE: rtl/lane_keep_pd_steering_top.sv
// Lane keeping PD steering controller with lane departure warning.
// Depends on lkps_pkg, lkps_cfg_if, lkps_in_if and lkps_out_if.
//
// channel  direction  handshake          payload
// cfg_ch   in         valid/ready        index, data (register write)
// in_ch    in         valid/ready        speed, qualities, offsets, turn, toggle
// out_ch   out        valid/ready        mode, torque, warnings, active, intensity
//
// A tick that runs the PD law passes the take, gain_d, gain_p and commit steps;
// others skip gain_p; one shared multiplier forms rate and gain products in turn.
// The result sits in an output register while the next request is taken.
// The commit step waits while an earlier result has not been taken.
// Reset is asynchronous; configuration writes are always accepted.
`default_nettype none
module lane_keep_pd_steering_top (
	input  logic              clk,
	input  logic              arst_n,
	lkps_cfg_if.sink          cfg_ch,
	lkps_in_if.sink           in_ch,
	lkps_out_if.source        out_ch
);

	logic [lkps_pkg::SPEED_W-1:0] min_speed_q;
	logic [lkps_pkg::GAIN_W-1:0]  gain_p_q;
	logic [lkps_pkg::GAIN_W-1:0]  gain_d_q;
	logic [lkps_pkg::RATE_W-1:0]  rate_scale_q;
	logic [lkps_pkg::LIMIT_W-1:0] torque_limit_q;
	logic [lkps_pkg::WARN_W-1:0]  warn_offset_q;
	logic [lkps_pkg::LIMIT_W-1:0] active_torque_q;

	logic [lkps_pkg::PC_W-1:0] pc_q;
	lkps_pkg::ctrl_t           ctrl;
	logic                      accept;
	logic                      jump;
	logic                      out_busy;
	logic                      out_valid_q;

	logic [lkps_pkg::SPEED_W-1:0]         speed_q;
	logic [lkps_pkg::QUAL_W-1:0]          lq_q;
	logic [lkps_pkg::QUAL_W-1:0]          rq_q;
	logic signed [lkps_pkg::OFFSET_W-1:0] loff_q;
	logic signed [lkps_pkg::OFFSET_W-1:0] roff_q;
	logic                                 turn_q;
	logic                                 toggle_q;

	lkps_pkg::mode_t                      mode_q;
	lkps_pkg::mode_t                      mode_nxt;
	logic signed [lkps_pkg::OFFSET_W-1:0] last_q;
	logic signed [lkps_pkg::TORQUE_W-1:0] torque_q;
	logic signed [lkps_pkg::TORQUE_W-1:0] torque_nxt;
	logic                                 active_q;
	logic                                 active_nxt;
	logic                                 depart_left_q;
	logic                                 depart_right_q;
	logic                                 depart_left_nxt;
	logic                                 depart_right_nxt;

	logic can;
	logic pd;

	logic signed [14:0] diff_in;
	logic signed [25:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [42:0] mul_p;
	logic signed [24:0] rate_q;
	logic signed [41:0] acc_q;

	logic signed [31:0] quot;
	logic signed [32:0] t_raw;
	logic signed [12:0] lim_hi;
	logic signed [12:0] lim_lo;
	logic signed [12:0] t_clip;
	logic [12:0]        t_mag;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q     <= lkps_pkg::MIN_SPEED_RST;
			gain_p_q        <= lkps_pkg::GAIN_P_RST;
			gain_d_q        <= lkps_pkg::GAIN_D_RST;
			rate_scale_q    <= lkps_pkg::RATE_SCALE_RST;
			torque_limit_q  <= lkps_pkg::TORQUE_LIMIT_RST;
			warn_offset_q   <= lkps_pkg::WARN_OFFSET_RST;
			active_torque_q <= lkps_pkg::ACTIVE_TORQUE_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				lkps_pkg::CFG_MIN_SPEED:     min_speed_q     <= cfg_ch.data[lkps_pkg::SPEED_W-1:0];
				lkps_pkg::CFG_GAIN_P:        gain_p_q        <= cfg_ch.data[lkps_pkg::GAIN_W-1:0];
				lkps_pkg::CFG_GAIN_D:        gain_d_q        <= cfg_ch.data[lkps_pkg::GAIN_W-1:0];
				lkps_pkg::CFG_RATE_SCALE:    rate_scale_q    <= cfg_ch.data[lkps_pkg::RATE_W-1:0];
				lkps_pkg::CFG_TORQUE_LIMIT:  torque_limit_q  <= cfg_ch.data[lkps_pkg::LIMIT_W-1:0];
				lkps_pkg::CFG_WARN_OFFSET:   warn_offset_q   <= cfg_ch.data[lkps_pkg::WARN_W-1:0];
				lkps_pkg::CFG_ACTIVE_TORQUE: active_torque_q <= cfg_ch.data[lkps_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	assign ctrl         = lkps_pkg::rom_word(pc_q);
	assign in_ch.ready  = ctrl.take;
	assign accept       = in_ch.valid && ctrl.take;
	assign out_busy     = out_valid_q && !out_ch.ready;

	always_comb begin
		case (ctrl.cond)
			lkps_pkg::COND_NEVER:   jump = 1'b0;
			lkps_pkg::COND_NOREQ:   jump = !in_ch.valid;
			lkps_pkg::COND_NOPD:    jump = !pd;
			lkps_pkg::COND_OUTBUSY: jump = out_busy;
			default:                jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= jump ? ctrl.target : pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			speed_q  <= in_ch.speed;
			lq_q     <= in_ch.qual_left;
			rq_q     <= in_ch.qual_right;
			loff_q   <= in_ch.left_offset;
			roff_q   <= in_ch.right_offset;
			turn_q   <= in_ch.blinker_left || in_ch.blinker_right;
			toggle_q <= in_ch.toggle;
		end
	end

	assign can = (speed_q >= min_speed_q) && ((lq_q != '0) || (rq_q != '0)) && !turn_q;
	assign pd  = (mode_q == lkps_pkg::MODE_INTERVENE) && can;

	// Shared multiplier.
	assign diff_in = 15'(in_ch.left_offset) - 15'(last_q);

	always_comb begin
		case (ctrl.msel)
			lkps_pkg::MSEL_RATE: begin
				mul_a = 26'(diff_in);
				mul_b = 17'({1'b0, rate_scale_q});
			end
			lkps_pkg::MSEL_D: begin
				mul_a = 26'(rate_q);
				mul_b = 17'({1'b0, gain_d_q});
			end
			lkps_pkg::MSEL_P: begin
				mul_a = 26'(loff_q);
				mul_b = 17'({1'b0, gain_p_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 43'(mul_a) * 43'(mul_b);

	always_ff @(posedge clk) begin
		if (accept && ctrl.msel == lkps_pkg::MSEL_RATE) begin
			rate_q <= mul_p[24:0];
		end
		if (ctrl.msel == lkps_pkg::MSEL_D) begin
			acc_q <= mul_p[41:0];
		end else if (ctrl.msel == lkps_pkg::MSEL_P) begin
			acc_q <= acc_q + mul_p[41:0];
		end
	end

	// Torque: negated floor of the sum over 1024, clamped to the limit and 12 bits.
	assign quot   = acc_q[41:10];
	assign t_raw  = -(33'(quot));
	assign lim_hi = (torque_limit_q > 12'd2047) ? 13'sd2047 : 13'(torque_limit_q);
	assign lim_lo = (torque_limit_q > 12'd2048) ? -13'sd2048 : -(13'(torque_limit_q));

	always_comb begin
		if (t_raw > 33'(lim_hi)) begin
			t_clip = lim_hi;
		end else if (t_raw < 33'(lim_lo)) begin
			t_clip = lim_lo;
		end else begin
			t_clip = t_raw[12:0];
		end
	end

	assign t_mag = t_clip[12] ? 13'(-t_clip) : 13'(t_clip);

	assign depart_left_nxt  = !turn_q && (lq_q != '0) &&
		(15'(loff_q) > $signed({2'b00, warn_offset_q}));
	assign depart_right_nxt = !turn_q && (rq_q != '0) &&
		(15'(roff_q) < -$signed({2'b00, warn_offset_q}));

	// Mode transition.
	always_comb begin
		case (mode_q)
			lkps_pkg::MODE_OFF:
				mode_nxt = toggle_q ? lkps_pkg::MODE_READY : lkps_pkg::MODE_OFF;
			lkps_pkg::MODE_READY: begin
				if (toggle_q) begin
					mode_nxt = lkps_pkg::MODE_OFF;
				end else begin
					mode_nxt = can ? lkps_pkg::MODE_PREP : lkps_pkg::MODE_READY;
				end
			end
			lkps_pkg::MODE_PREP:
				mode_nxt = can ? lkps_pkg::MODE_INTERVENE : lkps_pkg::MODE_READY;
			lkps_pkg::MODE_INTERVENE:
				mode_nxt = can ? lkps_pkg::MODE_INTERVENE : lkps_pkg::MODE_READY;
			default:
				mode_nxt = lkps_pkg::MODE_OFF;
		endcase
	end

	// Torque and flag updates per mode.
	always_comb begin
		torque_nxt = torque_q;
		active_nxt = active_q;
		case (mode_q)
			lkps_pkg::MODE_OFF:
				torque_nxt = '0;
			lkps_pkg::MODE_READY: begin
				if (!toggle_q) begin
					torque_nxt = '0;
				end
			end
			lkps_pkg::MODE_PREP: ;
			lkps_pkg::MODE_INTERVENE: begin
				if (can) begin
					torque_nxt = t_clip[lkps_pkg::TORQUE_W-1:0];
					active_nxt = t_mag > {1'b0, active_torque_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= lkps_pkg::MODE_OFF;
			last_q         <= '0;
			torque_q       <= '0;
			active_q       <= 1'b0;
			depart_left_q  <= 1'b0;
			depart_right_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (ctrl.commit && !out_busy) begin
			mode_q         <= mode_nxt;
			torque_q       <= torque_nxt;
			active_q       <= active_nxt;
			depart_left_q  <= depart_left_nxt;
			depart_right_q <= depart_right_nxt;
			if (pd) begin
				last_q <= loff_q;
			end
			out_valid_q    <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.mode         = mode_q;
	assign out_ch.torque       = torque_q;
	assign out_ch.depart_left  = depart_left_q;
	assign out_ch.depart_right = depart_right_q;
	assign out_ch.active       = active_q;
	assign out_ch.intensity    = (depart_left_q || depart_right_q) ? lkps_pkg::INTENS_ON
		: lkps_pkg::INTENS_OFF;

endmodule
`default_nettype wire

FILE: rtl/lkps_checker.sv
// Port checker for the lane keeping block, attached to the top level by bind.
// Depends on lkps_pkg and the top level lane_keep_pd_steering_top.
`default_nettype none
module lkps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lkps_pkg::TORQUE_W-1:0] out_torque,
	input logic [lkps_pkg::MODE_W-1:0]   out_mode
);

	// A request keeps the engine busy through its gain_d step and the step that follows it.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while a previous one is still in progress");

	// A new result appears only after the engine was busy.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a request in progress");

	// A waiting result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_torque) && $stable(out_mode))
		else $error("waiting result dropped or changed");

endmodule

bind lane_keep_pd_steering_top lkps_checker u_lkps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_torque (out_ch.torque),
	.out_mode   (out_ch.mode)
);
`default_nettype wire
